// File: hdl/hsv_range_pixel_ratio_detector_top_macros.svh
// assertion helpers shared by the detector modules
`ifndef HSV_RANGE_PIXEL_RATIO_DETECTOR_TOP_MACROS_SVH
`define HSV_RANGE_PIXEL_RATIO_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HSVR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define HSVR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/hsvr_pkg.sv
`timescale 1ns / 1ps

package hsvr_pkg;

   localparam int PIX_W     = 8;
   localparam int CNT_W     = 21;
   localparam int LIMIT_W   = 17;
   localparam int Q16_SHIFT = 16;
   localparam int PROD_W    = LIMIT_W + CNT_W;
   localparam int CSR_IDX_W = 8;

   localparam longint MAX_PIXELS    = 1048576;
   localparam longint CNT_FIELD_MAX = (longint'(1) << CNT_W) - 1;
   localparam longint CNT_CAP_L     = (MAX_PIXELS < CNT_FIELD_MAX) ? MAX_PIXELS : CNT_FIELD_MAX;
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_L);

   // sky rules
   localparam logic [PIX_W-1:0] SKY_ZERO_HUE_VAL_MIN = PIX_W'(200);
   localparam logic [PIX_W-1:0] SKY_PALE_VAL_MIN     = PIX_W'(145);
   localparam logic [PIX_W-1:0] SKY_PALE_SAT_MAX     = PIX_W'(20);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HUE_LOW     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_HUE_HIGH    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SAT_LOW     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SAT_HIGH    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_VAL_LOW     = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_VAL_HIGH    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_SKY_MODE    = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_LIMIT = CSR_IDX_W'(7);

   // register reset values
   localparam logic [PIX_W-1:0]   RST_HUE_LOW     = PIX_W'(0);
   localparam logic [PIX_W-1:0]   RST_HUE_HIGH    = PIX_W'(33);
   localparam logic [PIX_W-1:0]   RST_SAT_LOW     = PIX_W'(170);
   localparam logic [PIX_W-1:0]   RST_SAT_HIGH    = PIX_W'(255);
   localparam logic [PIX_W-1:0]   RST_VAL_LOW     = PIX_W'(100);
   localparam logic [PIX_W-1:0]   RST_VAL_HIGH    = PIX_W'(255);
   localparam logic               RST_SKY_MODE    = 1'b0;
   localparam logic [LIMIT_W-1:0] RST_RATIO_LIMIT = LIMIT_W'(32768);

   typedef struct packed {
      logic [PIX_W-1:0]   hue_low;
      logic [PIX_W-1:0]   hue_high;
      logic [PIX_W-1:0]   sat_low;
      logic [PIX_W-1:0]   sat_high;
      logic [PIX_W-1:0]   val_low;
      logic [PIX_W-1:0]   val_high;
      logic               sky_mode;
      logic [LIMIT_W-1:0] ratio_limit;
   } hsvr_cfg_type;

   // classified pixel
   typedef struct packed {
      logic hit;
      logic last;
   } hsvr_pix_type;

   // closed frame counts
   typedef struct packed {
      logic [CNT_W-1:0] match;
      logic [CNT_W-1:0] pixel;
   } hsvr_frame_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c < CNT_CAP) ? (c + CNT_W'(1)) : CNT_CAP;
   endfunction

endpackage

// File: hdl/hsvr_csr.sv
`timescale 1ns / 1ps

module hsvr_csr
   import hsvr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data,
   output hsvr_cfg_type         cfg
);

   hsvr_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_HUE_LOW:     cfg_in.hue_low     = csr_data[PIX_W-1:0];
            REG_HUE_HIGH:    cfg_in.hue_high    = csr_data[PIX_W-1:0];
            REG_SAT_LOW:     cfg_in.sat_low     = csr_data[PIX_W-1:0];
            REG_SAT_HIGH:    cfg_in.sat_high    = csr_data[PIX_W-1:0];
            REG_VAL_LOW:     cfg_in.val_low     = csr_data[PIX_W-1:0];
            REG_VAL_HIGH:    cfg_in.val_high    = csr_data[PIX_W-1:0];
            REG_SKY_MODE:    cfg_in.sky_mode    = csr_data[0];
            REG_RATIO_LIMIT: cfg_in.ratio_limit = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_low     <= RST_HUE_LOW;
         cfg_ff.hue_high    <= RST_HUE_HIGH;
         cfg_ff.sat_low     <= RST_SAT_LOW;
         cfg_ff.sat_high    <= RST_SAT_HIGH;
         cfg_ff.val_low     <= RST_VAL_LOW;
         cfg_ff.val_high    <= RST_VAL_HIGH;
         cfg_ff.sky_mode    <= RST_SKY_MODE;
         cfg_ff.ratio_limit <= RST_RATIO_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/hsvr_classify.sv
`timescale 1ns / 1ps

module hsvr_classify
   import hsvr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  hsvr_cfg_type     cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_hue,
   input  logic [PIX_W-1:0] req_saturation,
   input  logic [PIX_W-1:0] req_brightness,
   input  logic             req_frame_end,
   input  logic             pix_go,
   output logic             pix_valid,
   output hsvr_pix_type     pix
);

   logic         valid_ff, valid_in;
   hsvr_pix_type pix_ff, pix_in;
   logic         in_box, sky_hit, take;

   assign req_ready = !valid_ff || pix_go;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_box = (req_hue >= cfg.hue_low) && (req_hue <= cfg.hue_high) &&
               (req_saturation >= cfg.sat_low) && (req_saturation <= cfg.sat_high) &&
               (req_brightness >= cfg.val_low) && (req_brightness <= cfg.val_high);
      sky_hit = ((req_hue == '0) && (req_brightness > SKY_ZERO_HUE_VAL_MIN)) ||
                ((req_brightness > SKY_PALE_VAL_MIN) && (req_saturation < SKY_PALE_SAT_MAX));
      pix_in.hit  = in_box || (cfg.sky_mode && sky_hit);
      pix_in.last = req_frame_end;
      valid_in    = take || (valid_ff && !pix_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = valid_ff;
   assign pix       = pix_ff;

endmodule

// File: hdl/hsvr_counter.sv
`timescale 1ns / 1ps

`include "hsv_range_pixel_ratio_detector_top_macros.svh"

module hsvr_counter
   import hsvr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pix_valid,
   input  hsvr_pix_type   pix,
   output logic           pix_go,
   output logic           frame_valid,
   output hsvr_frame_type frame,
   input  logic           frame_ready
);

   logic [CNT_W-1:0] match_cnt_ff, match_cnt_in;
   logic [CNT_W-1:0] pixel_cnt_ff, pixel_cnt_in;
   logic             fvalid_ff, fvalid_in;
   hsvr_frame_type   frame_ff, frame_in;
   logic [CNT_W-1:0] match_next, pixel_next;
   logic             frame_free, close;

   assign frame_free = !fvalid_ff || frame_ready;
   // only a frame-closing pixel needs room downstream
   assign pix_go     = pix_valid && (!pix.last || frame_free);
   assign close      = pix_go && pix.last;

   always_comb begin
      match_next   = pix.hit ? sat_inc(match_cnt_ff) : match_cnt_ff;
      pixel_next   = sat_inc(pixel_cnt_ff);
      match_cnt_in = match_cnt_ff;
      pixel_cnt_in = pixel_cnt_ff;
      if (pix_go) begin
         match_cnt_in = close ? '0 : match_next;
         pixel_cnt_in = close ? '0 : pixel_next;
      end
      frame_in.match = match_next;
      frame_in.pixel = pixel_next;
      fvalid_in      = close || (fvalid_ff && !frame_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_cnt_ff <= '0;
         pixel_cnt_ff <= '0;
         fvalid_ff    <= 1'b0;
      end else begin
         match_cnt_ff <= match_cnt_in;
         pixel_cnt_ff <= pixel_cnt_in;
         fvalid_ff    <= fvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (close) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = fvalid_ff;
   assign frame       = frame_ff;

   `HSVR_ASSERT_IMP(a_match_le_pixel, 1'b1, match_cnt_ff <= pixel_cnt_ff, "match count above pixel count")
   `HSVR_ASSERT_IMP(a_pixel_capped, 1'b1, pixel_cnt_ff <= CNT_CAP, "pixel count past cap")
   `HSVR_ASSERT_NXT(a_close_clears, close, (match_cnt_ff == '0) && (pixel_cnt_ff == '0), "counters not cleared at frame end")

endmodule

// File: hdl/hsvr_decide.sv
`timescale 1ns / 1ps

`include "hsv_range_pixel_ratio_detector_top_macros.svh"

module hsvr_decide
   import hsvr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  hsvr_cfg_type     cfg,
   input  logic             frame_valid,
   input  hsvr_frame_type   frame,
   output logic             frame_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_detected,
   output logic [CNT_W-1:0] rsp_match_total,
   output logic [CNT_W-1:0] rsp_pixel_total
);

   logic              pvalid_ff, pvalid_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   hsvr_frame_type    cnt_ff;
   logic              rvalid_ff, rvalid_in;
   logic              det_ff, det_in;
   logic [CNT_W-1:0]  match_ff, pixel_ff;
   logic [PROD_W-1:0] lhs;
   logic              out_en, p_free, p_load;

   assign out_en      = !rvalid_ff || rsp_ready;
   assign p_free      = !pvalid_ff || out_en;
   assign p_load      = frame_valid && p_free;
   assign frame_ready = p_free;

   always_comb begin
      prod_in   = PROD_W'(cfg.ratio_limit) * PROD_W'(frame.pixel);
      lhs       = PROD_W'(cnt_ff.match) << Q16_SHIFT;
      det_in    = cfg.sky_mode ? (lhs >= prod_ff) : (lhs > prod_ff);
      pvalid_in = p_free ? frame_valid : pvalid_ff;
      rvalid_in = out_en ? pvalid_ff : rvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_load) begin
         prod_ff <= prod_in;
         cnt_ff  <= frame;
      end
      if (out_en && pvalid_ff) begin
         det_ff   <= det_in;
         match_ff <= cnt_ff.match;
         pixel_ff <= cnt_ff.pixel;
      end
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_detected    = det_ff;
   assign rsp_match_total = match_ff;
   assign rsp_pixel_total = pixel_ff;

   `HSVR_ASSERT_NXT(a_prod_held, pvalid_ff && !out_en, pvalid_ff, "pending product dropped while stalled")
   `HSVR_ASSERT_IMP(a_det_needs_match, rvalid_ff && det_ff && (cfg.ratio_limit != '0), match_ff != '0, "detection with no matched pixel")
   `HSVR_ASSERT_IMP(a_total_order, rvalid_ff, match_ff <= pixel_ff, "result match total above pixel total")

endmodule

// File: hdl/hsv_range_pixel_ratio_detector_top.sv
`timescale 1ns / 1ps

// HSV box pixel ratio detector. Takes one HSV pixel per clock and counts the pixels that fall in
// the programmed hue/saturation/value box (plus the bright-grey and zero-hue sky rules when
// sky_mode is set). The pixel with frame_end high closes the frame: it is counted, the matched
// fraction is compared against ratio_limit (unsigned Q1.16, strict in object mode, >= in sky
// mode) and one result with the detection flag and both saturating counts is sent; only that
// pixel makes a result. Throughput is one pixel per cycle. After the frame_end pixel transfers
// it passes the pixel register, then the count, threshold multiply and compare registers.
// A result held on rsp stalls req only when a frame_end pixel reaches the counter while the
// result, product and closed-frame registers all hold frames; other pixels keep flowing.
// Registers must be written through the csr port only while no frame is in flight; the block
// does not enforce this. Index 7 carries the full 17-bit limit.
module hsv_range_pixel_ratio_detector_top
   import hsvr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_hue,
   input  logic [PIX_W-1:0]     req_saturation,
   input  logic [PIX_W-1:0]     req_brightness,
   input  logic                 req_frame_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_detected,
   output logic [CNT_W-1:0]     rsp_match_total,
   output logic [CNT_W-1:0]     rsp_pixel_total
);

   hsvr_cfg_type   cfg;
   hsvr_pix_type   pix;
   hsvr_frame_type frame;
   logic           pix_valid, pix_go;
   logic           frame_valid, frame_ready;

   hsvr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hsvr_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .req_frame_end  (req_frame_end),
      .pix_go         (pix_go),
      .pix_valid      (pix_valid),
      .pix            (pix)
   );

   hsvr_counter u_counter (
      .clock       (clock),
      .reset       (reset),
      .pix_valid   (pix_valid),
      .pix         (pix),
      .pix_go      (pix_go),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready)
   );

   hsvr_decide u_decide (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .frame_valid     (frame_valid),
      .frame           (frame),
      .frame_ready     (frame_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_detected    (rsp_detected),
      .rsp_match_total (rsp_match_total),
      .rsp_pixel_total (rsp_pixel_total)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import hsvr_pkg::*;

   localparam int IDLE_PCT       = 9;
   localparam int SETTLE_CYCLES  = 10;
   localparam int CYCLE_LIMIT    = 100000;
   localparam int MAX_REPORTS    = 10;
   localparam int QUEUE_DEPTH    = 32;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 180;
   localparam int PRESSURE_PHASE = 2;
   localparam int STEADY_PHASE   = 5;

   // counters stop at the smaller of 2^20 pixels and the 21-bit field
   localparam logic [CNT_W-1:0]     FRAME_PIXEL_CAP = CNT_W'(1 << 20);
   localparam logic [LIMIT_W-1:0]   LIMIT_ONE       = LIMIT_W'(65536);
   localparam logic [LIMIT_W-1:0]   LIMIT_MAX       = '1;
   localparam logic [PIX_W-1:0]     PIX_MAX         = '1;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED    = REG_RATIO_LIMIT + 1'b1;
   localparam logic [PIX_W-1:0]     ZERO_HUE_BRIGHT = 8'd200;
   localparam logic [PIX_W-1:0]     PALE_BRIGHT     = 8'd145;
   localparam logic [PIX_W-1:0]     PALE_SAT_LIMIT  = 8'd20;

   typedef struct packed {
      logic [PIX_W-1:0] hue;
      logic [PIX_W-1:0] sat;
      logic [PIX_W-1:0] val;
      logic             last;
   } pixel_type;

   typedef struct packed {
      logic             detected;
      logic [CNT_W-1:0] matched;
      logic [CNT_W-1:0] seen;
   } verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LIMIT_W-1:0]   csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_hue = '0;
   logic [PIX_W-1:0]     req_saturation = '0;
   logic [PIX_W-1:0]     req_brightness = '0;
   logic                 req_frame_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_detected;
   logic [CNT_W-1:0]     rsp_match_total;
   logic [CNT_W-1:0]     rsp_pixel_total;

   hsvr_cfg_type     box;
   logic [CNT_W-1:0] matched_n;
   logic [CNT_W-1:0] seen_n;
   pixel_type        pending_pixels[$];
   verdict_type      verdicts_due[$];
   pixel_type        next_pixel;
   verdict_type      want;
   int               bad_frames = 0;
   bit               no_idle = 1'b0;
   int               hold_request = 0;
   int               hold_left = 0;
   bit               req_xfer = 1'b0;
   int               cycle_count = 0;

   hsv_range_pixel_ratio_detector_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_hue         (req_hue),
      .req_saturation  (req_saturation),
      .req_brightness  (req_brightness),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_detected    (rsp_detected),
      .rsp_match_total (rsp_match_total),
      .rsp_pixel_total (rsp_pixel_total)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      return (c < FRAME_PIXEL_CAP) ? c + 1'b1 : FRAME_PIXEL_CAP;
   endfunction

   task automatic apply_write(input logic [CSR_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
      case (idx)
         REG_HUE_LOW:     box.hue_low = data[PIX_W-1:0];
         REG_HUE_HIGH:    box.hue_high = data[PIX_W-1:0];
         REG_SAT_LOW:     box.sat_low = data[PIX_W-1:0];
         REG_SAT_HIGH:    box.sat_high = data[PIX_W-1:0];
         REG_VAL_LOW:     box.val_low = data[PIX_W-1:0];
         REG_VAL_HIGH:    box.val_high = data[PIX_W-1:0];
         REG_SKY_MODE:    box.sky_mode = data[0];
         REG_RATIO_LIMIT: box.ratio_limit = data;
         default: ;
      endcase
   endtask

   task automatic count_pixel(input pixel_type p);
      logic        hit;
      logic [63:0] lhs;
      logic [63:0] rhs;
      verdict_type v;
      hit = p.hue >= box.hue_low && p.hue <= box.hue_high &&
            p.sat >= box.sat_low && p.sat <= box.sat_high &&
            p.val >= box.val_low && p.val <= box.val_high;
      if (box.sky_mode) begin
         hit = hit || (p.hue == '0 && p.val > ZERO_HUE_BRIGHT) ||
               (p.val > PALE_BRIGHT && p.sat < PALE_SAT_LIMIT);
      end
      seen_n = bump(seen_n);
      if (hit) begin
         matched_n = bump(matched_n);
      end
      if (p.last) begin
         // fraction against Q1.16 limit, cross-multiplied
         lhs = 64'(matched_n) << 16;
         rhs = 64'(box.ratio_limit) * 64'(seen_n);
         v.detected = box.sky_mode ? (lhs >= rhs) : (lhs > rhs);
         v.matched = matched_n;
         v.seen = seen_n;
         verdicts_due.push_back(v);
         matched_n = '0;
         seen_n = '0;
      end
   endtask

   always @(posedge clock) begin
      req_xfer <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            count_pixel({req_hue, req_saturation, req_brightness, req_frame_end});
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               bad_frames++;
               if (bad_frames <= MAX_REPORTS) begin
                  $display("unexpected result: det=%0b match=%0d pixels=%0d",
                           rsp_detected, rsp_match_total, rsp_pixel_total);
               end
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_detected !== want.detected || rsp_match_total !== want.matched ||
                   rsp_pixel_total !== want.seen) begin
                  bad_frames++;
                  if (bad_frames <= MAX_REPORTS) begin
                     $display("result mismatch: expected det=%0b match=%0d pixels=%0d, got det=%0b match=%0d pixels=%0d",
                              want.detected, want.matched, want.seen,
                              rsp_detected, rsp_match_total, rsp_pixel_total);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // pixel sender: a new transfer is offered only once the last one went through
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (pending_pixels.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_pixel = pending_pixels.pop_front();
            req_valid <= 1'b1;
            req_hue <= next_pixel.hue;
            req_saturation <= next_pixel.sat;
            req_brightness <= next_pixel.val;
            req_frame_end <= next_pixel.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic queue_pixel(input logic [PIX_W-1:0] h, input logic [PIX_W-1:0] s,
                              input logic [PIX_W-1:0] v, input logic last);
      while (pending_pixels.size() >= QUEUE_DEPTH) @(posedge clock);
      pending_pixels.push_back('{hue: h, sat: s, val: v, last: last});
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || verdicts_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // byte registers get junk in the upper bits, which must be dropped
   task automatic program_box(input logic [PIX_W-1:0] h_lo, input logic [PIX_W-1:0] h_hi,
                              input logic [PIX_W-1:0] s_lo, input logic [PIX_W-1:0] s_hi,
                              input logic [PIX_W-1:0] v_lo, input logic [PIX_W-1:0] v_hi,
                              input logic sky, input logic [LIMIT_W-1:0] limit);
      write_reg(REG_HUE_LOW, {(LIMIT_W-PIX_W)'($urandom), h_lo});
      write_reg(REG_HUE_HIGH, {(LIMIT_W-PIX_W)'($urandom), h_hi});
      write_reg(REG_SAT_LOW, {(LIMIT_W-PIX_W)'($urandom), s_lo});
      write_reg(REG_SAT_HIGH, {(LIMIT_W-PIX_W)'($urandom), s_hi});
      write_reg(REG_VAL_LOW, {(LIMIT_W-PIX_W)'($urandom), v_lo});
      write_reg(REG_VAL_HIGH, {(LIMIT_W-PIX_W)'($urandom), v_hi});
      write_reg(REG_SKY_MODE, {(LIMIT_W-1)'($urandom), sky});
      write_reg(REG_RATIO_LIMIT, limit);
   endtask

   task automatic pick_span(output logic [PIX_W-1:0] lo, output logic [PIX_W-1:0] hi);
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      a = PIX_W'($urandom);
      b = PIX_W'($urandom);
      // mostly ordered bounds, sometimes inverted
      if ($urandom_range(0, 4) != 0 && a > b) begin
         lo = b;
         hi = a;
      end else begin
         lo = a;
         hi = b;
      end
   endtask

   initial begin
      logic [PIX_W-1:0]   h_lo, h_hi, s_lo, s_hi, v_lo, v_hi;
      logic [PIX_W-1:0]   h, s, v;
      logic [LIMIT_W-1:0] limit;
      int                 phase, items, len, k, pick;

      box = '{hue_low: 8'd0, hue_high: 8'd33, sat_low: 8'd170, sat_high: 8'd255,
              val_low: 8'd100, val_high: 8'd255, sky_mode: 1'b0, ratio_limit: 17'd32768};
      matched_n = '0;
      seen_n = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-on box: edges of every bound, then a full match
      queue_pixel(0, 170, 100, 0);
      queue_pixel(33, 255, 255, 0);
      queue_pixel(34, 170, 100, 0);
      queue_pixel(0, 169, 100, 0);
      queue_pixel(0, 255, 99, 1);
      queue_pixel(255, 255, 255, 1);
      queue_pixel(10, 200, 200, 0);
      queue_pixel(10, 200, 200, 1);
      wait_idle();

      // inverted hue bounds in sky mode, ratio lands exactly on the limit
      write_reg(REG_HUE_LOW, 17'h1FFFA);
      write_reg(REG_HUE_HIGH, 17'd5);
      write_reg(REG_SKY_MODE, 17'd1);
      write_reg(REG_UNMAPPED, 17'h1ABCD);
      queue_pixel(0, 100, 201, 0);
      queue_pixel(0, 100, 200, 0);
      queue_pixel(1, 19, 146, 0);
      queue_pixel(1, 20, 146, 0);
      queue_pixel(1, 19, 145, 0);
      queue_pixel(255, 0, 255, 1);
      wait_idle();

      // strict compare at equality fails in object mode
      program_box(0, PIX_MAX, 0, PIX_MAX, 0, 127, 1'b0, 17'd32768);
      queue_pixel(7, 7, 0, 0);
      queue_pixel(7, 7, PIX_MAX, 1);
      wait_idle();
      program_box(0, PIX_MAX, 0, PIX_MAX, 0, PIX_MAX, 1'b0, LIMIT_MAX);
      queue_pixel(1, 2, 3, 1);
      wait_idle();
      write_reg(REG_RATIO_LIMIT, LIMIT_ONE);
      write_reg(REG_SKY_MODE, 17'd1);
      queue_pixel(1, 2, 3, 1);
      wait_idle();
      program_box(0, PIX_MAX, 0, PIX_MAX, PIX_MAX, 0, 1'b1, '0);
      queue_pixel(5, 100, 100, 1);
      wait_idle();
      write_reg(REG_SKY_MODE, 17'd0);
      queue_pixel(5, 100, 100, 1);
      wait_idle();

      for (phase = 0; phase < PHASES; phase++) begin
         pick_span(h_lo, h_hi);
         pick_span(s_lo, s_hi);
         pick_span(v_lo, v_hi);
         case ($urandom_range(0, 5))
            0: limit = '0;
            1: limit = LIMIT_ONE;
            2: limit = LIMIT_MAX;
            default: limit = LIMIT_W'($urandom_range(0, LIMIT_ONE));
         endcase
         program_box(h_lo, h_hi, s_lo, s_hi, v_lo, v_hi, 1'($urandom_range(0, 1)), limit);
         write_reg(CSR_IDX_W'($urandom_range(REG_UNMAPPED, (1 << CSR_IDX_W) - 1)),
                   LIMIT_W'($urandom));
         if (phase == PRESSURE_PHASE) begin
            hold_request = HOLD_CYCLES;
         end
         no_idle = (phase == STEADY_PHASE);
         items = 0;
         while (items < PHASE_ITEMS) begin
            if (phase == PRESSURE_PHASE) begin
               len = $urandom_range(1, 2);
            end else if ($urandom_range(0, 9) == 0) begin
               len = $urandom_range(20, 80);
            end else begin
               len = $urandom_range(1, 8);
            end
            for (k = 0; k < len; k++) begin
               h = PIX_W'($urandom);
               s = PIX_W'($urandom);
               v = PIX_W'($urandom);
               pick = $urandom_range(0, 9);
               if (pick < 5) begin
                  // aim inside the box where the bounds allow it
                  if (box.hue_low <= box.hue_high) begin
                     h = PIX_W'($urandom_range(box.hue_low, box.hue_high));
                  end
                  if (box.sat_low <= box.sat_high) begin
                     s = PIX_W'($urandom_range(box.sat_low, box.sat_high));
                  end
                  if (box.val_low <= box.val_high) begin
                     v = PIX_W'($urandom_range(box.val_low, box.val_high));
                  end
               end else if (pick < 7) begin
                  // near the sky rule edges
                  if ($urandom_range(0, 1) == 0) begin
                     h = '0;
                     v = PIX_W'($urandom_range(ZERO_HUE_BRIGHT - 5, PIX_MAX));
                  end else begin
                     v = PIX_W'($urandom_range(PALE_BRIGHT - 5, PIX_MAX));
                     s = PIX_W'($urandom_range(0, PALE_SAT_LIMIT + 5));
                  end
               end
               queue_pixel(h, s, v, k == len - 1);
            end
            items += len;
         end
         wait_idle();
      end
      no_idle = 1'b0;

      if (bad_frames == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
